// File: rtl/vce_pkg.sv
// Shared types and constants for the vertex-corrected pseudorapidity pipeline.
package vce_pkg;

  // Register indexes on the configuration port (paddr[3:2])
  localparam logic [1:0] REG_RADIUS   = 2'd0;
  localparam logic [1:0] REG_DISTANCE = 2'd1;
  localparam logic [1:0] REG_BOUNDARY = 2'd2;

  localparam logic [12:0] RADIUS_RST   = 13'd2184;
  localparam logic [13:0] DISTANCE_RST = 14'd5248;
  localparam logic [14:0] BOUNDARY_RST = 15'd6058;

  // Datapath sizing
  localparam int LN_TAB_MAX = 24;   // deepest table entry any CORDIC depth reads
  localparam int KMAX       = 11;   // largest power-of-two exponent of |eta|/ln2
  localparam int ZQ_W       = 41;   // quotient bits of |z|/radius in Q28
  localparam int EQ_W       = 54;   // quotient bits of sinh*dist/len
  localparam int ROOT_STEPS = 32;   // one result bit per step of the square root
  localparam int DQ_W       = 25;   // quotient bits of 2^55/u for large arguments
  localparam int V_W        = 58;   // log argument width

  localparam logic [29:0] ONE_Q28 = 30'h1000_0000;
  localparam logic [29:0] TWO_Q28 = 30'h2000_0000;

  typedef logic [LN_TAB_MAX:0][27:0] ln_tab_t;

  // ln(2) and ln(1 + 2^-i) in Q28, summed as power series in Q62 and rounded
  function automatic ln_tab_t ln_table();
    ln_tab_t tab;
    longint unsigned acc;
    longint unsigned term;
    for (int i = 0; i <= LN_TAB_MAX; i++) begin
      acc = 0;
      if (i == 0) begin
        for (int n = 1; n <= 62; n++) begin
          acc = acc + (64'd1 << (62 - n)) / 64'(n);
        end
      end else begin
        for (int n = 1; i * n <= 62; n++) begin
          term = (64'd1 << (62 - i * n)) / 64'(n);
          if (n % 2 == 1) acc = acc + term;
          else acc = acc - term;
        end
      end
      tab[i] = 28'((acc + (64'd1 << 33)) >> 34);
    end
    return tab;
  endfunction

  localparam ln_tab_t     LN_TAB = ln_table();
  localparam logic [27:0] LN2    = LN_TAB[0];

  // Everything one item carries down the pipeline; lane 0 barrel, lane 1 endcap
  typedef struct packed {
    logic signed [15:0] eta;
    logic signed [12:0] z;
    logic               eta_neg;
    logic               a_zero;
    logic               z_neg;
    logic [32:0]        big;
    logic [3:0]         k;
    logic [27:0]        t1;
    logic [27:0]        t2;
    logic [29:0]        e1;
    logic [29:0]        e2;
    logic [40:0]        zrem;
    logic [40:0]        zq;
    logic [40:0]        p_val;
    logic [29:0]        q_val;
    logic [40:0]        s;
    logic               s_zero;
    logic               zlen_neg;
    logic               lm_zero;
    logic [14:0]        lm;
    logic               neg_b;
    logic [53:0]        erem;
    logic [53:0]        eq;
    logic [1:0][55:0]   u;
    logic [1:0]         ubig;
    logic [1:0]         uz;
    logic [1:0][63:0]   w;
    logic [1:0][63:0]   root;
    logic [1:0][55:0]   drem;
    logic [1:0][24:0]   dq;
    logic [1:0][57:0]   v;
    logic [1:0][5:0]    msb;
    logic [1:0][4:0]    m;
    logic [1:0][29:0]   y;
    logic [1:0][28:0]   acc;
    logic [1:0][33:0]   ln;
    logic [1:0][17:0]   mag;
    logic [15:0]        eta_out;
    logic               endcap;
    logic               clip;
  } vce_item_t;

endpackage

// File: rtl/vertex_corrected_eta_core.sv
// Vertex-corrected pseudorapidity: fully pipelined fixed-point datapath.
//
// Input stream s_*: eta_in (Q12) and vertex_z (1/16 cm). Output stream m_*:
// eta_out (Q12) with the endcap_used and clipped flags in tuser. The APB port
// holds barrel radius, endcap distance and barrel/endcap boundary; write them
// only while no item is in flight.
// Each item passes a fixed chain of registers: sinh by a shift-add exp unit,
// |z|/radius and the endcap quotient by one-bit-per-stage restoring dividers,
// asinh by a one-bit-per-stage square root and a shift-add log unit, the
// barrel and endcap hypotheses side by side. Most of the pipeline depth lies
// in the 54-bit endcap divider and the 32-step square root. One item is
// accepted every cycle while the output is not stalled.
// A stalled receiver holds the whole pipeline: s_tready drops with m_tready
// while the last stage holds an item, and nothing is lost or repeated.
// Reset empties the pipeline and loads the register defaults.
module vertex_corrected_eta_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] eta_in, [28:16] vertex_z, [31:29] zero
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] eta_out
  output logic [1:0]  m_tuser    // [0] endcap_used, [1] clipped
);
  import vce_pkg::*;

  localparam int S_IN   = 0;
  localparam int S_K    = 1;
  localparam int S_R    = 2;
  localparam int S_ZDIV = 3;
  localparam int S_EXPF = S_ZDIV + ZQ_W;
  localparam int S_SH   = S_EXPF + 1;
  localparam int S_SS   = S_SH + 1;
  localparam int S_X    = S_SS + 1;
  localparam int S_EDIV = S_X + 1;
  localparam int S_SQ   = S_EDIV + EQ_W;
  localparam int S_ROOT = S_SQ + 1;
  localparam int S_V    = S_ROOT + ROOT_STEPS;
  localparam int S_LOD  = S_V + 1;
  localparam int S_NORM = S_LOD + 1;
  localparam int S_LOG  = S_NORM + 1;
  localparam int S_FIN  = S_LOG + CORDIC_STAGES;
  localparam int S_Q12  = S_FIN + 1;
  localparam int S_OUT  = S_Q12 + 1;
  localparam int DEPTH  = S_OUT + 1;

  logic [12:0] radius;
  logic [13:0] distance;
  logic [14:0] boundary;
  logic [12:0] rad_eff;
  logic [13:0] dist_eff;
  logic        cfg_wr;

  vce_item_t        pipe [DEPTH];
  vce_item_t        nxt  [DEPTH];
  logic [DEPTH-1:0] vld;
  logic             adv;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius   <= RADIUS_RST;
      distance <= DISTANCE_RST;
      boundary <= BOUNDARY_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_RADIUS:   radius   <= pwdata[12:0];
        REG_DISTANCE: distance <= pwdata[13:0];
        REG_BOUNDARY: boundary <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RADIUS:   prdata = 32'(radius);
      REG_DISTANCE: prdata = 32'(distance);
      REG_BOUNDARY: prdata = 32'(boundary);
      default:      prdata = 32'd0;
    endcase
  end

  // Zero radius or distance behaves as one
  assign rad_eff  = (radius == 13'd0) ? 13'd1 : radius;
  assign dist_eff = (distance == 14'd0) ? 14'd1 : distance;

  // Whole pipeline advances unless the output item is stuck
  assign adv      = !vld[DEPTH-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[DEPTH-1];
  assign m_tdata  = pipe[DEPTH-1].eta_out;
  assign m_tuser  = {pipe[DEPTH-1].clip, pipe[DEPTH-1].endcap};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], s_tvalid};
    end
    if (adv) begin
      for (int i = 0; i < DEPTH; i++) begin
        pipe[i] <= nxt[i];
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_stage
    localparam int PREV = (g == 0) ? 0 : g - 1;

    if (g == S_IN) begin : g_in
      // Capture the item
      always_comb begin
        nxt[g]     = '0;
        nxt[g].eta = s_tdata[15:0];
        nxt[g].z   = s_tdata[28:16];
      end

    end else if (g == S_K) begin : g_k
      // Take magnitudes, count whole ln2 steps in |eta|
      always_comb begin
        logic [16:0] a;
        logic [12:0] zabs;
        logic [32:0] big;
        logic [3:0]  kc;
        nxt[g] = pipe[PREV];
        a    = pipe[PREV].eta[15] ? 17'(17'd0 - {pipe[PREV].eta[15], pipe[PREV].eta})
                                  : 17'({pipe[PREV].eta[15], pipe[PREV].eta});
        zabs = pipe[PREV].z[12] ? 13'(13'd0 - pipe[PREV].z) : pipe[PREV].z;
        big  = {a, 16'd0};
        kc   = 4'd0;
        for (int j = 1; j <= KMAX; j++) begin
          if (big >= 33'(j) * 33'(LN2)) kc = kc + 4'd1;
        end
        nxt[g].eta_neg = pipe[PREV].eta[15];
        nxt[g].z_neg   = pipe[PREV].z[12];
        nxt[g].a_zero  = (a == 17'd0);
        nxt[g].big     = big;
        nxt[g].k       = kc;
        nxt[g].zrem    = {zabs, 28'd0};
        nxt[g].zq      = '0;
      end

    end else if (g == S_R) begin : g_r
      // Split off the remainder below ln2
      always_comb begin
        logic [32:0] r;
        nxt[g]    = pipe[PREV];
        r         = pipe[PREV].big - 33'(pipe[PREV].k) * 33'(LN2);
        nxt[g].t1 = r[27:0];
        nxt[g].t2 = LN2 - r[27:0];
        nxt[g].e1 = ONE_Q28;
        nxt[g].e2 = ONE_Q28;
      end

    end else if (g >= S_ZDIV && g < S_EXPF) begin : g_zdiv
      localparam int J   = g - S_ZDIV;
      localparam int B   = ZQ_W - 1 - J;
      localparam bit EON = (J + 1) <= CORDIC_STAGES;
      localparam int EI  = EON ? J + 1 : 1;
      // One quotient bit of |z|/radius; one exp step on both exponents in the first CORDIC_STAGES stages
      always_comb begin
        logic [53:0] dv;
        nxt[g] = pipe[PREV];
        dv = 54'(rad_eff) << B;
        if (54'(pipe[PREV].zrem) >= dv) begin
          nxt[g].zrem  = 41'(54'(pipe[PREV].zrem) - dv);
          nxt[g].zq[B] = 1'b1;
        end
        if (EON) begin
          if (pipe[PREV].t1 >= LN_TAB[EI]) begin
            nxt[g].t1 = pipe[PREV].t1 - LN_TAB[EI];
            nxt[g].e1 = pipe[PREV].e1 + (pipe[PREV].e1 >> EI);
          end
          if (pipe[PREV].t2 >= LN_TAB[EI]) begin
            nxt[g].t2 = pipe[PREV].t2 - LN_TAB[EI];
            nxt[g].e2 = pipe[PREV].e2 + (pipe[PREV].e2 >> EI);
          end
        end
      end

    end else if (g == S_EXPF) begin : g_expf
      // Linear correction with the leftover argument
      always_comb begin
        logic [57:0] p1;
        logic [57:0] p2;
        nxt[g]    = pipe[PREV];
        p1        = 58'(pipe[PREV].e1) * 58'(pipe[PREV].t1);
        p2        = 58'(pipe[PREV].e2) * 58'(pipe[PREV].t2);
        nxt[g].e1 = pipe[PREV].e1 + 30'(p1 >> 28);
        nxt[g].e2 = pipe[PREV].e2 + 30'(p2 >> 28);
      end

    end else if (g == S_SH) begin : g_sh
      // Scale both exponentials by the power of two
      always_comb begin
        nxt[g]       = pipe[PREV];
        nxt[g].p_val = 41'(pipe[PREV].e1) << pipe[PREV].k;
        nxt[g].q_val = pipe[PREV].e2 >> (pipe[PREV].k + 4'd1);
      end

    end else if (g == S_SS) begin : g_ss
      // Form sinh and the endcap path length
      always_comb begin
        logic [40:0] s;
        logic [15:0] zend;
        logic [15:0] zlen;
        nxt[g] = pipe[PREV];
        if (!pipe[PREV].a_zero && pipe[PREV].p_val > 41'(pipe[PREV].q_val)) begin
          s = (pipe[PREV].p_val - 41'(pipe[PREV].q_val)) >> 1;
        end else begin
          s = '0;
        end
        zend = pipe[PREV].eta_neg ? 16'(16'd0 - 16'(dist_eff)) : 16'(dist_eff);
        zlen = zend - {{3{pipe[PREV].z[12]}}, pipe[PREV].z};
        nxt[g].s        = s;
        nxt[g].s_zero   = (s == 41'd0);
        nxt[g].zlen_neg = zlen[15];
        nxt[g].lm       = zlen[15] ? 15'(16'd0 - zlen) : zlen[14:0];
        nxt[g].lm_zero  = (zlen == 16'd0);
      end

    end else if (g == S_X) begin : g_x
      // Barrel argument and endcap numerator
      always_comb begin
        logic [42:0] sx;
        logic [42:0] zx;
        logic [42:0] x;
        logic [54:0] pr;
        nxt[g] = pipe[PREV];
        sx = pipe[PREV].eta_neg ? 43'(43'd0 - 43'(pipe[PREV].s)) : 43'(pipe[PREV].s);
        zx = pipe[PREV].z_neg ? 43'(43'd0 - 43'(pipe[PREV].zq)) : 43'(pipe[PREV].zq);
        x  = sx + zx;
        pr = 55'(pipe[PREV].s) * 55'(dist_eff);
        nxt[g].neg_b = x[42];
        nxt[g].u[0]  = 56'(x[42] ? 43'(43'd0 - x) : x);
        nxt[g].erem  = pr[53:0];
        nxt[g].eq    = '0;
      end

    end else if (g >= S_EDIV && g < S_SQ) begin : g_ediv
      localparam int J = g - S_EDIV;
      localparam int B = EQ_W - 1 - J;
      // One quotient bit of the endcap argument
      always_comb begin
        logic [68:0] dv;
        logic [14:0] lm_div;
        nxt[g] = pipe[PREV];
        lm_div = pipe[PREV].lm_zero ? 15'd1 : pipe[PREV].lm;
        dv     = 69'(lm_div) << B;
        if (69'(pipe[PREV].erem) >= dv) begin
          nxt[g].erem  = 54'(69'(pipe[PREV].erem) - dv);
          nxt[g].eq[B] = 1'b1;
        end
      end

    end else if (g == S_SQ) begin : g_sq
      // Set up root and reciprocal for both asinh lanes
      always_comb begin
        logic [1:0][55:0] uu;
        nxt[g] = pipe[PREV];
        uu[0]  = pipe[PREV].u[0];
        uu[1]  = 56'(pipe[PREV].eq);
        for (int l = 0; l < 2; l++) begin
          nxt[g].u[l]    = uu[l];
          nxt[g].ubig[l] = (uu[l][55:31] != '0);
          nxt[g].uz[l]   = (uu[l] == '0);
          nxt[g].w[l]    = 64'(uu[l][30:0]) * 64'(uu[l][30:0]) + (64'd1 << 56);
          nxt[g].root[l] = '0;
          nxt[g].drem[l] = 56'd1 << 55;
          nxt[g].dq[l]   = '0;
        end
      end

    end else if (g >= S_ROOT && g < S_V) begin : g_root
      localparam int          J   = g - S_ROOT;
      localparam logic [63:0] RB  = 64'd1 << (62 - 2 * J);
      localparam bit          DON = J < DQ_W;
      localparam int          DB  = DON ? DQ_W - 1 - J : 0;
      // One root digit per lane, plus one reciprocal quotient bit in the first DQ_W stages
      always_comb begin
        logic [63:0] rb;
        logic [80:0] dv;
        nxt[g] = pipe[PREV];
        for (int l = 0; l < 2; l++) begin
          rb = pipe[PREV].root[l] + RB;
          if (pipe[PREV].w[l] >= rb) begin
            nxt[g].w[l]    = pipe[PREV].w[l] - rb;
            nxt[g].root[l] = (pipe[PREV].root[l] >> 1) + RB;
          end else begin
            nxt[g].root[l] = pipe[PREV].root[l] >> 1;
          end
          dv = 81'(pipe[PREV].u[l]) << DB;
          if (DON && 81'(pipe[PREV].drem[l]) >= dv) begin
            nxt[g].drem[l]   = 56'(81'(pipe[PREV].drem[l]) - dv);
            nxt[g].dq[l][DB] = 1'b1;
          end
        end
      end

    end else if (g == S_V) begin : g_v
      // Pick the log argument
      always_comb begin
        nxt[g] = pipe[PREV];
        for (int l = 0; l < 2; l++) begin
          if (pipe[PREV].ubig[l]) begin
            nxt[g].v[l] = {pipe[PREV].u[l], 1'b0} + 58'(pipe[PREV].dq[l]);
          end else begin
            nxt[g].v[l] = 58'(pipe[PREV].u[l]) + 58'(pipe[PREV].root[l]);
          end
        end
      end

    end else if (g == S_LOD) begin : g_lod
      // Find the leading one
      always_comb begin
        nxt[g] = pipe[PREV];
        for (int l = 0; l < 2; l++) begin
          nxt[g].msb[l] = '0;
          for (int i = 0; i < V_W; i++) begin
            if (pipe[PREV].v[l][i]) nxt[g].msb[l] = 6'(i);
          end
        end
      end

    end else if (g == S_NORM) begin : g_norm
      // Normalise into [1, 2)
      always_comb begin
        logic [4:0] m;
        nxt[g] = pipe[PREV];
        for (int l = 0; l < 2; l++) begin
          m = (pipe[PREV].msb[l] >= 6'd28) ? 5'(pipe[PREV].msb[l] - 6'd28) : 5'd0;
          nxt[g].m[l]   = m;
          nxt[g].y[l]   = 30'(pipe[PREV].v[l] >> m);
          nxt[g].acc[l] = '0;
        end
      end

    end else if (g >= S_LOG && g < S_FIN) begin : g_log
      localparam int I = g - S_LOG + 1;
      // One shift-add log step per lane
      always_comb begin
        logic [29:0] t;
        nxt[g] = pipe[PREV];
        for (int l = 0; l < 2; l++) begin
          t = pipe[PREV].y[l] + (pipe[PREV].y[l] >> I);
          if (t <= TWO_Q28) begin
            nxt[g].y[l]   = t;
            nxt[g].acc[l] = pipe[PREV].acc[l] + 29'(LN_TAB[I]);
          end
        end
      end

    end else if (g == S_FIN) begin : g_fin
      // Assemble the logarithm, floor at zero
      always_comb begin
        logic [33:0] total;
        logic [33:0] sub;
        nxt[g] = pipe[PREV];
        for (int l = 0; l < 2; l++) begin
          total = (34'(pipe[PREV].m[l]) + 34'd1) * 34'(LN2);
          sub   = 34'(pipe[PREV].acc[l]) + 34'((TWO_Q28 - pipe[PREV].y[l]) >> 1);
          nxt[g].ln[l] = (total > sub) ? total - sub : 34'd0;
        end
      end

    end else if (g == S_Q12) begin : g_q12
      // Round to Q12
      always_comb begin
        nxt[g] = pipe[PREV];
        for (int l = 0; l < 2; l++) begin
          nxt[g].mag[l] = pipe[PREV].uz[l] ? 18'd0
                        : 18'((pipe[PREV].ln[l] + 34'h8000) >> 16);
        end
      end

    end else begin : g_out
      // Choose barrel or endcap, saturate, apply sign
      always_comb begin
        logic [17:0] mg;
        logic        ng;
        logic        ec;
        logic        inf;
        logic        cl;
        nxt[g] = pipe[PREV];
        ec  = pipe[PREV].mag[0] > 18'(boundary);
        mg  = pipe[PREV].mag[0];
        ng  = pipe[PREV].neg_b;
        inf = 1'b0;
        if (ec) begin
          if (pipe[PREV].s_zero) begin
            mg = '0;
            ng = 1'b0;
          end else if (pipe[PREV].lm_zero) begin
            inf = 1'b1;
            ng  = pipe[PREV].eta_neg;
          end else begin
            mg = pipe[PREV].mag[1];
            ng = pipe[PREV].zlen_neg;
          end
        end
        cl = inf || (mg > 18'd32767);
        if (cl) mg = 18'd32767;
        nxt[g].eta_out = ng ? 16'(16'd0 - mg[15:0]) : mg[15:0];
        nxt[g].endcap  = ec;
        nxt[g].clip    = cl;
      end
    end
  end

endmodule

// File: tb/tb.sv
// Testbench for the vertex-corrected pseudorapidity core: stream stimulus, APB setup, checks.
`timescale 1ns / 1ps

import vce_pkg::*;

typedef struct {
  logic signed [15:0] eta_out;
  logic               endcap;
  logic               clip;
} eta_result_t;

class eta_scoreboard;
  localparam int STAGES = 16;
  longint unsigned ln_q28 [0:STAGES];
  logic [12:0] radius;
  logic [13:0] distance;
  logic [14:0] boundary;
  eta_result_t expected_q[$];
  int fails;
  int n_items;
  int n_endcap;
  int n_clip;

  function new();
    longint unsigned acc;
    longint unsigned term;
    radius   = RADIUS_RST;
    distance = DISTANCE_RST;
    boundary = BOUNDARY_RST;
    fails = 0;
    n_items = 0;
    n_endcap = 0;
    n_clip = 0;
    // ln(2), then ln(1 + 2^-i), as series in Q62 rounded to Q28
    acc = 0;
    for (int n = 1; n <= 62; n++) acc += (64'd1 << (62 - n)) / longint'(n);
    ln_q28[0] = (acc + (64'd1 << 33)) >> 34;
    for (int i = 1; i <= STAGES; i++) begin
      acc = 0;
      for (int n = 1; i * n <= 62; n++) begin
        term = (64'd1 << (62 - i * n)) / longint'(n);
        if (n % 2 == 1) acc += term;
        else acc -= term;
      end
      ln_q28[i] = (acc + (64'd1 << 33)) >> 34;
    end
  endfunction

  // shift-add exponential for 0 <= t <= ln2, Q28
  function longint unsigned exp_q28(longint unsigned t);
    longint unsigned e;
    e = 64'd1 << 28;
    for (int i = 1; i <= STAGES; i++) begin
      if (t >= ln_q28[i]) begin
        t -= ln_q28[i];
        e += e >> i;
      end
    end
    e += (e * t) >> 28;
    return e;
  endfunction

  function longint unsigned floor_sqrt(longint unsigned w);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > w) bitv >>= 2;
    while (bitv != 0) begin
      if (w >= root + bitv) begin
        w -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // asinh of a Q28 magnitude, rounded to Q12
  function longint unsigned asinh_q12(longint unsigned u);
    longint unsigned v, y, acc, total, sub, t, res;
    int p, m;
    if (u == 0) return 0;
    if (u < (64'd1 << 31)) v = u + floor_sqrt(u * u + (64'd1 << 56));
    else v = 2 * u + (64'd1 << 55) / u;
    p = 0;
    while (p < 63 && (v >> (p + 1)) != 0) p++;
    m = p - 28;
    y = v >> m;
    acc = 0;
    for (int i = 1; i <= STAGES; i++) begin
      t = y + (y >> i);
      if (t <= (64'd1 << 29)) begin
        y = t;
        acc += ln_q28[i];
      end
    end
    total = longint'(m + 1) * ln_q28[0];
    sub = acc + (((64'd1 << 29) - y) >> 1);
    res = total > sub ? total - sub : 0;
    return (res + (64'd1 << 15)) >> 16;
  endfunction

  function eta_result_t correct_eta(logic signed [15:0] eta, logic signed [12:0] z);
    eta_result_t res;
    longint unsigned a, big, k, r, pv, qv, s, zmag, mag, rad, dist_v, lm;
    longint x, zq, zend, zlen;
    bit neg, inf;
    rad    = (radius == 0) ? 1 : radius;
    dist_v = (distance == 0) ? 1 : distance;
    a = (eta < 0) ? -longint'(eta) : longint'(eta);
    s = 0;
    if (a != 0) begin
      big = a << 16;
      k = big / ln_q28[0];
      r = big - k * ln_q28[0];
      pv = exp_q28(r) << k;
      qv = exp_q28(ln_q28[0] - r) >> (k + 1);
      s = (pv > qv) ? (pv - qv) >> 1 : 0;
    end
    // barrel hypothesis
    zmag = (longint'((z < 0) ? -longint'(z) : longint'(z)) << 28) / rad;
    zq = (z < 0) ? -longint'(zmag) : longint'(zmag);
    x = ((eta < 0) ? -longint'(s) : longint'(s)) + zq;
    neg = x < 0;
    mag = asinh_q12(neg ? -x : x);
    res.endcap = 0;
    inf = 0;
    // endcap reprojection
    if (mag > boundary) begin
      res.endcap = 1;
      zend = (eta < 0) ? -longint'(dist_v) : longint'(dist_v);
      zlen = zend - longint'(z);
      if (s == 0) begin
        mag = 0;
        neg = 0;
      end else if (zlen == 0) begin
        inf = 1;
        neg = eta < 0;
      end else begin
        lm = (zlen < 0) ? -zlen : zlen;
        neg = zlen < 0;
        mag = asinh_q12((s * dist_v) / lm);
      end
    end
    res.clip = inf || mag > 32767;
    if (res.clip) mag = 32767;
    res.eta_out = neg ? 16'(-longint'(mag)) : 16'(mag);
    return res;
  endfunction

  function void note_item(logic [15:0] eta, logic [12:0] z);
    eta_result_t res;
    res = correct_eta(eta, z);
    expected_q.push_back(res);
    n_items++;
    if (res.endcap) n_endcap++;
    if (res.clip) n_clip++;
  endfunction

  function void check_item(logic [15:0] data, logic [1:0] user);
    eta_result_t res;
    if (expected_q.size() == 0) begin
      $error("unexpected result eta_out=%0d", $signed(data));
      fails++;
      return;
    end
    res = expected_q.pop_front();
    if (data !== res.eta_out) begin
      $error("eta_out: expected %0d, got %0d", res.eta_out, $signed(data));
      fails++;
    end
    if (user[0] !== res.endcap) begin
      $error("endcap_used: expected %0b, got %0b", res.endcap, user[0]);
      fails++;
    end
    if (user[1] !== res.clip) begin
      $error("clipped: expected %0b, got %0b", res.clip, user[1]);
      fails++;
    end
  endfunction
endclass

module tb;
  localparam int LATENCY = 16 + 140;

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [15:0] eta_in, [28:16] vertex_z, [31:29] zero
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [15:0] m_tdata;        // [15:0] eta_out
  logic [1:0]  m_tuser;        // [0] endcap_used, [1] clipped

  eta_scoreboard sb = new();
  bit no_idle = 0;
  bit hold_req = 0;

  vertex_corrected_eta_core u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // check every accepted result
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_item(m_tdata, m_tuser);
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 0;
        hold_req = 0;
        repeat (400) @(posedge clk);
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 9);
        if (n > 0) begin
          m_tready <= 0;
          repeat (n) @(posedge clk);
        end
      end
      m_tready <= 1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      REG_RADIUS:   sb.radius = value[12:0];
      REG_DISTANCE: sb.distance = value[13:0];
      default:      sb.boundary = value[14:0];
    endcase
  endtask

  task automatic set_geometry(int rad, int dist_v, int bnd);
    reg_write(REG_RADIUS, rad);
    reg_write(REG_DISTANCE, dist_v);
    reg_write(REG_BOUNDARY, bnd);
  endtask

  // offer one item, hold it until taken
  task automatic send_item(logic [15:0] eta, logic [12:0] z);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {3'b000, z, eta};
    do @(posedge clk); while (!s_tready);
    sb.note_item(eta, z);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic directed_items(int dist_v);
    logic signed [15:0] etas[6] = '{16'sh8000, 16'sh7fff, 0, 1, -1, 16'sh2000};
    logic signed [12:0] zs[3] = '{-4096, 4095, 0};
    foreach (etas[i]) foreach (zs[j]) send_item(etas[i], zs[j]);
    // vertex on and beyond the endcap plane
    if (dist_v <= 4095) begin
      send_item(16'sh6000, 13'(dist_v));
      send_item(-16'sh6000, 13'(-dist_v));
      send_item(16'sh4000, 13'(dist_v < 4095 ? dist_v + 1 : dist_v));
      send_item(16'sh0000, 13'(dist_v));
    end
  endtask

  // busy keeps the caller's no_idle, so with it set the sender offers an item every cycle
  task automatic random_items(int count, int dist_v, bit busy);
    logic [15:0] eta;
    logic [12:0] z;
    for (int i = 0; i < count; i++) begin
      if (!busy && i % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
      eta = 16'($urandom);
      if ($urandom_range(0, 3) == 0) eta = 16'($signed(eta) >>> $urandom_range(1, 6));
      z = 13'($urandom);
      if (dist_v <= 4095 && $urandom_range(0, 15) == 0) begin
        z = $urandom_range(0, 1) ? 13'(dist_v) : 13'(-dist_v);
        if (!$urandom_range(0, 3)) z = z + 13'($urandom_range(0, 2)) - 13'd1;
      end
      send_item(eta, z);
    end
    no_idle = 0;
  endtask

  initial begin
    int rad[5] = '{2184, 1, 8191, 300, 4000};
    int dist_set[5] = '{5248, 1, 16383, 1000, 4095};
    int bnd[5] = '{6058, 0, 32767, 4000, 12000};
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) set_geometry(rad[ph], dist_set[ph], bnd[ph]);
      directed_items(dist_set[ph]);
      if (ph == 0) begin
        // stall the output long enough that the pipeline backs up
        no_idle = 1;
        hold_req = 1;
        random_items(120, dist_set[ph], 1'b1);
        random_items(80, dist_set[ph], 1'b0);
      end else begin
        random_items(200, dist_set[ph], 1'b0);
      end
      drain();
    end
    repeat (LATENCY + 20) @(posedge clk);
    $display("covered %0d items over five register settings, including the extremes",
             sb.n_items);
    $display("endcap reprojections %0d, saturated results %0d", sb.n_endcap, sb.n_clip);
    if (sb.fails == 0 && sb.expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", sb.expected_q.size());
    $display("end of test: mismatches");
    $finish;
  end
endmodule

// File: vertex_corrected_eta_core.f
rtl/vce_pkg.sv
rtl/vertex_corrected_eta_core.sv
tb/tb.sv
